/* rtl/mbe_pkg.sv */
// shared types, constants and helpers for the mandelbrot escape-time unit
`default_nettype none

package mbe_pkg;

    localparam int Q_W    = 32;
    localparam int PROD_W = 64;
    localparam int ITER_W = 17;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef logic signed [Q_W-1:0]    q_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic [ITER_W-1:0]        iter_t;

    typedef enum logic [1:0] {
        REG_START_X  = 2'd0,
        REG_START_Y  = 2'd1,
        REG_STEP     = 2'd2,
        REG_MAX_ITER = 2'd3
    } reg_idx_t;

    localparam logic [31:0] START_X_RST  = 32'hE000_0000;
    localparam logic [31:0] START_Y_RST  = 32'hECCC_CCCD;
    localparam logic [30:0] STEP_RST     = 31'h0010_0000;
    localparam logic [15:0] MAX_ITER_RST = 16'd255;

    typedef struct packed {
        q_t          start_x;
        q_t          start_y;
        logic [30:0] step;
        logic [15:0] max_iter;
    } cfg_t;

    typedef struct packed {
        q_t a0;
        q_t b0;
        q_t a1;
        q_t b1;
        q_t a2;
        q_t b2;
    } mul_in_t;

    typedef struct packed {
        prod_t p0;
        prod_t p1;
        prod_t p2;
    } mul_out_t;

    // true when the value fits the signed 32-bit range
    function automatic logic in_q(input prod_t v);
        logic [PROD_W-Q_W:0] top;
        top = v[PROD_W-1:Q_W-1];
        return (&top) | (~|top);
    endfunction

    function automatic q_t sat_q(input prod_t v);
        q_t r;
        if (in_q(v))
        begin
            r = v[Q_W-1:0];
        end
        else if (v[PROD_W-1])
        begin
            r = {1'b1, {(Q_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(Q_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic prod_t sext_q(input q_t v);
        return {{(PROD_W-Q_W){v[Q_W-1]}}, v};
    endfunction

endpackage

`default_nettype wire

/* rtl/mbe_cfg_regs.sv */
// configuration register file behind the apb port
`default_nettype none

module mbe_cfg_regs (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [mbe_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mbe_pkg::DATA_W-1:0] pwdata,
    output logic      [mbe_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    output mbe_pkg::cfg_t                  cfg
);
    import mbe_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_START_X:  cfg_next.start_x  = q_t'(pwdata);
                REG_START_Y:  cfg_next.start_y  = q_t'(pwdata);
                REG_STEP:     cfg_next.step     = pwdata[30:0];
                REG_MAX_ITER: cfg_next.max_iter = pwdata[15:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_START_X:  prdata = cfg_reg.start_x;
            REG_START_Y:  prdata = cfg_reg.start_y;
            REG_STEP:     prdata = {1'b0, cfg_reg.step};
            REG_MAX_ITER: prdata = {16'd0, cfg_reg.max_iter};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_x  <= q_t'(START_X_RST);
            cfg_reg.start_y  <= q_t'(START_Y_RST);
            cfg_reg.step     <= STEP_RST;
            cfg_reg.max_iter <= MAX_ITER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/mbe_mul_unit.sv */
// shared three-lane signed multiplier with registered products
`default_nettype none

module mbe_mul_unit (
    input  wire logic              clk,
    input  mbe_pkg::mul_in_t       opnd,
    output mbe_pkg::mul_out_t      prod
);
    import mbe_pkg::*;

    mul_out_t prod_reg;
    mul_out_t prod_next;

    always_comb
    begin
        prod_next.p0 = sext_q(opnd.a0) * sext_q(opnd.b0);
        prod_next.p1 = sext_q(opnd.a1) * sext_q(opnd.b1);
        prod_next.p2 = sext_q(opnd.a2) * sext_q(opnd.b2);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* rtl/mandelbrot_escape_time_unit.sv */
// top level: pixel mapping and escape-time iteration sequencer
// steps: S_MAP, S_COORD, then S_SQUARE and S_UPDATE per iteration, then S_FINISH
// one request at a time: in_stall is high until the sequencer is back in S_IDLE
// each iteration is one pass through the shared multiplier, then one update; |z|^2 > 4 ends the run
// reset: async active low, clears sequencer and output valid, config to defaults
`default_nettype none

module mandelbrot_escape_time_unit #(
    parameter int PIXEL_INDEX_BITS = 12,
    parameter int FRAC_BITS        = 28,
    parameter int COUNT_BITS       = 17
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mbe_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [mbe_pkg::DATA_W-1:0]  pwdata,
    output logic      [mbe_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [PIXEL_INDEX_BITS-1:0] col,
    input  wire logic [PIXEL_INDEX_BITS-1:0] row,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [COUNT_BITS-1:0]       count
);
    import mbe_pkg::*;

    localparam logic [PROD_W-1:0] LIMIT = PROD_W'(4) << (2 * FRAC_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_COORD,
        S_SQUARE,
        S_UPDATE,
        S_FINISH
    } state_t;

    cfg_t     cfg;
    mul_in_t  opnd;
    mul_out_t prod;

    state_t                      state_reg, state_next;
    iter_t                       cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic [PIXEL_INDEX_BITS-1:0] col_reg, col_next;
    logic [PIXEL_INDEX_BITS-1:0] row_reg, row_next;
    q_t                          cx_reg, cx_next;
    q_t                          cy_reg, cy_next;
    q_t                          zx_reg, zx_next;
    q_t                          zy_reg, zy_next;
    iter_t                       res_reg, res_next;
    logic [COUNT_BITS-1:0]       count_reg, count_next;

    prod_t       nx_w;
    prod_t       ny_w;
    logic [PROD_W-1:0] mag;
    iter_t       cnt_inc;
    logic [31:0] res_wide;

    mbe_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbe_mul_unit u_mul (
        .clk  (clk),
        .opnd (opnd),
        .prod (prod)
    );

    // operand select: pixel mapping or z squares and cross term
    always_comb
    begin
        if (state_reg == S_MAP)
        begin
            opnd.a0 = q_t'({1'b0, cfg.step});
            opnd.b0 = q_t'({{(Q_W-PIXEL_INDEX_BITS){1'b0}}, col_reg});
            opnd.a1 = q_t'({1'b0, cfg.step});
            opnd.b1 = q_t'({{(Q_W-PIXEL_INDEX_BITS){1'b0}}, row_reg});
            opnd.a2 = '0;
            opnd.b2 = '0;
        end
        else
        begin
            opnd.a0 = zx_reg;
            opnd.b0 = zx_reg;
            opnd.a1 = zy_reg;
            opnd.b1 = zy_reg;
            opnd.a2 = zx_reg;
            opnd.b2 = zy_reg;
        end
    end

    assign nx_w     = ((prod.p0 - prod.p1) >>> FRAC_BITS) + sext_q(cx_reg);
    assign ny_w     = (prod.p2 >>> (FRAC_BITS - 1)) + sext_q(cy_reg);
    assign mag      = $unsigned(prod.p0) + $unsigned(prod.p1);
    assign cnt_inc  = cnt_reg + 1'b1;
    assign res_wide = 32'(res_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        col_next       = col_reg;
        row_next       = row_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        zx_next        = zx_reg;
        zy_next        = zy_reg;
        res_next       = res_reg;
        count_next     = count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    col_next   = col;
                    row_next   = row;
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                state_next = S_COORD;
            end
            S_COORD:
            begin
                cx_next    = sat_q(sext_q(cfg.start_x) + prod.p0);
                cy_next    = sat_q(sext_q(cfg.start_y) + prod.p1);
                zx_next    = '0;
                zy_next    = '0;
                cnt_next   = '0;
                state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if ((cnt_reg != '0) && (mag > LIMIT))
                begin
                    res_next   = cnt_reg;
                    state_next = S_FINISH;
                end
                else if (!in_q(nx_w) || !in_q(ny_w) ||
                         (cnt_reg == iter_t'(cfg.max_iter)))
                begin
                    res_next   = cnt_inc;
                    state_next = S_FINISH;
                end
                else
                begin
                    zx_next    = nx_w[Q_W-1:0];
                    zy_next    = ny_w[Q_W-1:0];
                    cnt_next   = cnt_inc;
                    state_next = S_SQUARE;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    count_next     = res_wide[COUNT_BITS-1:0];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg   <= col_next;
        row_reg   <= row_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        zx_reg    <= zx_next;
        zy_reg    <= zy_next;
        res_reg   <= res_next;
        count_reg <= count_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign count     = count_reg;

endmodule

`default_nettype wire
